@@ sv/cwrp_pkg.sv @@
// Shared types and constants for the window-size report parser.
// Byte codes, size limits, phase type, reply buffer depth and accumulate function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwrp_pkg;

    // reply buffer depth default
    localparam int REPLY_BYTES_DEF = 128;

    // accumulator width and saturation point for the size fields
    localparam int SIZE_W    = 10;
    localparam int SAT_LIMIT = 1000;
    localparam int SIZE_MAX  = 999;

    // byte codes of the report syntax
    localparam logic [7:0] CH_CSI   = 8'h9B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // field numbers inside the report
    localparam logic [1:0] FLD_ROWS = 2'd2;
    localparam logic [1:0] FLD_COLS = 2'd3;

    // parse phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIELDS,
        PH_SPACE
    } t_phase;

    // decimal accumulate with saturation at the limit
    function automatic logic [SIZE_W-1:0] acc_digit(input logic [SIZE_W-1:0] acc,
                                                    input logic [3:0]        digit);
        logic [SIZE_W+3:0] v;
        v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{SIZE_W{1'b0}}, digit};
        if (v >= (SIZE_W+4)'(SAT_LIMIT)) begin
            return SIZE_W'(SAT_LIMIT);
        end
        return v[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/csi_window_report_parser_unit.sv @@
// Top level of the window-size report parser: byte parser plus result buffering.
// Depends on cwrp_pkg for byte codes, phase type and the accumulate function.
`timescale 1ns / 1ps
`default_nettype none

// Scans a console reply one byte per beat for a window-size report: CSI (0x9B),
// four decimal fields split by three ';', then ' ' and 'r'. Every accepted
// byte yields exactly one result beat; report_found is set, with rows,
// columns and the report's byte range, on the 'r' of a valid report, and all
// other fields are zero otherwise. i_first_byte restarts offsets and parse at
// the byte it comes with; bytes beyond REPLY_BYTES are ignored (zero result).
// Throughput is one byte per cycle while o_stall is low: the parse state
// updates in the accepting cycle; the result goes to the output or skid register.
// A two-entry output buffer (output register plus skid register) keeps input
// accepted while a result waits; o_stall rises only when both are occupied.
module csi_window_report_parser_unit #(
    parameter int REPLY_BYTES = cwrp_pkg::REPLY_BYTES_DEF
) (
    input  wire  logic                               i_clk,
    input  wire  logic                               i_rst_n,
    // input channel
    input  wire  logic                               i_valid,
    output logic                                     o_stall,
    input  wire  logic [7:0]                         i_reply_byte,
    input  wire  logic                               i_first_byte,
    // result channel
    output logic                                     o_valid,
    input  wire  logic                               i_stall,
    output logic                                     o_report_found,
    output logic [cwrp_pkg::SIZE_W-1:0]              o_row_count,
    output logic [cwrp_pkg::SIZE_W-1:0]              o_column_count,
    output logic [$clog2(REPLY_BYTES)-1:0]           o_report_begin,
    output logic [$clog2(REPLY_BYTES+1)-1:0]         o_report_stop
);
    import cwrp_pkg::*;

    localparam int BW = $clog2(REPLY_BYTES);
    localparam int PW = $clog2(REPLY_BYTES + 1);

    // parse state
    t_phase            r_phase, n_phase;
    logic [1:0]        r_idx, n_idx;
    logic [SIZE_W-1:0] r_rows, n_rows;
    logic [SIZE_W-1:0] r_cols, n_cols;
    logic [PW-1:0]     r_pos, n_pos;
    logic [BW-1:0]     r_csi, n_csi;

    // view of the state after a first-byte clear
    t_phase            e_phase;
    logic [1:0]        e_idx;
    logic [SIZE_W-1:0] e_rows;
    logic [SIZE_W-1:0] e_cols;
    logic [PW-1:0]     e_pos;
    logic              in_range;
    logic              is_digit;
    logic [3:0]        digit;

    // result of the current beat
    logic              res_found;
    logic [SIZE_W-1:0] res_rows;
    logic [SIZE_W-1:0] res_cols;
    logic [BW-1:0]     res_begin;
    logic [PW-1:0]     res_stop;

    // output and skid registers
    logic              r_out_valid, r_skid_valid;
    logic              r_out_found, r_skid_found;
    logic [SIZE_W-1:0] r_out_rows, r_skid_rows;
    logic [SIZE_W-1:0] r_out_cols, r_skid_cols;
    logic [BW-1:0]     r_out_begin, r_skid_begin;
    logic [PW-1:0]     r_out_stop, r_skid_stop;

    logic accept;
    logic take;

    assign accept  = i_valid && !r_skid_valid;
    assign take    = r_out_valid && !i_stall;
    assign o_stall = r_skid_valid;

    // first byte clears offset and parse before the byte is taken
    always_comb begin
        if (i_first_byte) begin
            e_phase = PH_IDLE;
            e_idx   = 2'd0;
            e_rows  = '0;
            e_cols  = '0;
            e_pos   = '0;
        end else begin
            e_phase = r_phase;
            e_idx   = r_idx;
            e_rows  = r_rows;
            e_cols  = r_cols;
            e_pos   = r_pos;
        end
        in_range = e_pos < PW'(REPLY_BYTES);
        is_digit = i_reply_byte inside {[CH_ZERO:CH_NINE]};
        digit    = 4'(i_reply_byte - CH_ZERO);
    end

    // next parse state
    always_comb begin
        n_phase = e_phase;
        n_idx   = e_idx;
        n_rows  = e_rows;
        n_cols  = e_cols;
        n_pos   = e_pos;
        n_csi   = r_csi;
        if (in_range) begin
            n_pos = e_pos + PW'(1);
            if (i_reply_byte == CH_CSI) begin
                n_phase = PH_FIELDS;
                n_idx   = 2'd0;
                n_rows  = '0;
                n_cols  = '0;
                n_csi   = e_pos[BW-1:0];
            end else begin
                case (e_phase)
                    PH_FIELDS: begin
                        if (is_digit) begin
                            if (e_idx == FLD_ROWS) begin
                                n_rows = acc_digit(e_rows, digit);
                            end else if (e_idx == FLD_COLS) begin
                                n_cols = acc_digit(e_cols, digit);
                            end
                        end else if (i_reply_byte == CH_SEMI && e_idx != FLD_COLS) begin
                            n_idx = e_idx + 2'd1;
                        end else if (i_reply_byte == CH_SPACE && e_idx == FLD_COLS) begin
                            n_phase = PH_SPACE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // result of this beat
    always_comb begin
        res_found = 1'b0;
        res_rows  = '0;
        res_cols  = '0;
        res_begin = '0;
        res_stop  = '0;
        if (in_range && i_reply_byte != CH_CSI && e_phase == PH_SPACE &&
            i_reply_byte == CH_R &&
            e_rows != '0 && e_rows <= SIZE_W'(SIZE_MAX) &&
            e_cols != '0 && e_cols <= SIZE_W'(SIZE_MAX)) begin
            res_found = 1'b1;
            res_rows  = e_rows;
            res_cols  = e_cols;
            res_begin = r_csi;
            res_stop  = e_pos + PW'(1);
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= 2'd0;
            r_rows  <= '0;
            r_cols  <= '0;
            r_pos   <= '0;
            r_csi   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_pos   <= n_pos;
            r_csi   <= n_csi;
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take) begin
                r_out_valid <= r_skid_valid || accept;
            end
            if (take && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (accept && r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_found <= r_skid_found;
                r_out_rows  <= r_skid_rows;
                r_out_cols  <= r_skid_cols;
                r_out_begin <= r_skid_begin;
                r_out_stop  <= r_skid_stop;
            end else if (accept) begin
                r_out_found <= res_found;
                r_out_rows  <= res_rows;
                r_out_cols  <= res_cols;
                r_out_begin <= res_begin;
                r_out_stop  <= res_stop;
            end
        end
        if (accept && r_out_valid && !take) begin
            r_skid_found <= res_found;
            r_skid_rows  <= res_rows;
            r_skid_cols  <= res_cols;
            r_skid_begin <= res_begin;
            r_skid_stop  <= res_stop;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_report_found = r_out_found;
    assign o_row_count    = r_out_rows;
    assign o_column_count = r_out_cols;
    assign o_report_begin = r_out_begin;
    assign o_report_stop  = r_out_stop;

`ifndef SYNTHESIS
    // skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    // a reported size is always in range
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_report_found) |->
            (o_row_count != '0 && o_row_count <= SIZE_W'(SIZE_MAX) &&
             o_column_count != '0 && o_column_count <= SIZE_W'(SIZE_MAX)))
        else $error("report found with size out of range");

    // a report ends after its CSI byte
    a_stop_after_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_report_found) |-> (o_report_stop > PW'(o_report_begin)))
        else $error("report stop not after report begin");

    // waiting for 'r' only after all three separators
    a_space_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SPACE) |-> (r_idx == FLD_COLS))
        else $error("space phase with fewer than three separators");

    // offset never runs past the buffer
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(REPLY_BYTES))
        else $error("byte offset beyond reply buffer");
`endif

endmodule

`default_nettype wire

@@ verif/tb_csi_window_report_parser_unit.sv @@
// Self-checking testbench for the window-size report parser top level.
// Uses cwrp_pkg for byte codes, phase type and size limits; needs only the RTL.
`timescale 1ns / 1ps

// one result beat as the block presents it
typedef struct packed {
    logic       found;
    logic [9:0] rows;
    logic [9:0] cols;
    logic [6:0] start_ofs;
    logic [7:0] stop_ofs;
} t_report;

typedef logic [7:0] t_byte_q[$];

// tracks the parse of the reply stream and holds the reports still owed
class report_scoreboard;
    cwrp_pkg::t_phase phase;
    logic [1:0]       field_no;
    logic [9:0]       row_acc;
    logic [9:0]       col_acc;
    int unsigned      byte_ofs;
    logic [6:0]       csi_ofs;
    t_report          owed_reports[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      reports;
    int unsigned      dropped_bytes;

    function new();
        phase         = cwrp_pkg::PH_IDLE;
        field_no      = '0;
        row_acc       = '0;
        col_acc       = '0;
        byte_ofs      = 0;
        csi_ofs       = '0;
        mismatches    = 0;
        checked       = 0;
        reports       = 0;
        dropped_bytes = 0;
    endfunction

    // decimal shift-in, pinned at the saturation point
    local function logic [9:0] shift_digit(logic [9:0] acc, logic [7:0] ch);
        int unsigned v;
        v = acc * 10 + (ch - cwrp_pkg::CH_ZERO);
        if (v >= cwrp_pkg::SAT_LIMIT) begin
            v = cwrp_pkg::SAT_LIMIT;
        end
        return 10'(v);
    endfunction

    // advance the parse by one accepted byte and queue the result it owes
    function void note_byte(logic [7:0] ch, logic first_flag);
        t_report     r;
        int unsigned ofs;
        r = '0;
        if (first_flag) begin
            byte_ofs = 0;
            phase    = cwrp_pkg::PH_IDLE;
            field_no = '0;
            row_acc  = '0;
            col_acc  = '0;
        end
        if (byte_ofs >= cwrp_pkg::REPLY_BYTES_DEF) begin
            dropped_bytes++;
            owed_reports.push_back(r);
            return;
        end
        ofs      = byte_ofs;
        byte_ofs = byte_ofs + 1;
        if (ch == cwrp_pkg::CH_CSI) begin
            phase    = cwrp_pkg::PH_FIELDS;
            field_no = '0;
            row_acc  = '0;
            col_acc  = '0;
            csi_ofs  = 7'(ofs);
        end else begin
            case (phase)
                cwrp_pkg::PH_FIELDS: begin
                    if (ch >= cwrp_pkg::CH_ZERO && ch <= cwrp_pkg::CH_NINE) begin
                        if (field_no == cwrp_pkg::FLD_ROWS) begin
                            row_acc = shift_digit(row_acc, ch);
                        end else if (field_no == cwrp_pkg::FLD_COLS) begin
                            col_acc = shift_digit(col_acc, ch);
                        end
                    end else if (ch == cwrp_pkg::CH_SEMI && field_no < cwrp_pkg::FLD_COLS) begin
                        field_no = field_no + 2'd1;
                    end else if (ch == cwrp_pkg::CH_SPACE && field_no == cwrp_pkg::FLD_COLS) begin
                        phase = cwrp_pkg::PH_SPACE;
                    end else begin
                        phase = cwrp_pkg::PH_IDLE;
                    end
                end
                cwrp_pkg::PH_SPACE: begin
                    phase = cwrp_pkg::PH_IDLE;
                    if (ch == cwrp_pkg::CH_R &&
                        row_acc >= 1 && row_acc <= cwrp_pkg::SIZE_MAX &&
                        col_acc >= 1 && col_acc <= cwrp_pkg::SIZE_MAX) begin
                        r.found     = 1'b1;
                        r.rows      = row_acc;
                        r.cols      = col_acc;
                        r.start_ofs = csi_ofs;
                        r.stop_ofs  = 8'(ofs + 1);
                        reports++;
                    end
                end
                default: begin
                    phase = cwrp_pkg::PH_IDLE;
                end
            endcase
        end
        owed_reports.push_back(r);
    endfunction

    // compare one result beat against the oldest owed result
    function void check_result(t_report got);
        t_report want;
        if (owed_reports.size() == 0) begin
            $error("result beat with no byte outstanding (found=%0d)", got.found);
            mismatches++;
            return;
        end
        want = owed_reports.pop_front();
        checked++;
        if (got.found !== want.found) begin
            $error("report_found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
        end
        if (got.rows !== want.rows) begin
            $error("row_count: expected %0d, got %0d", want.rows, got.rows);
            mismatches++;
        end
        if (got.cols !== want.cols) begin
            $error("column_count: expected %0d, got %0d", want.cols, got.cols);
            mismatches++;
        end
        if (got.start_ofs !== want.start_ofs) begin
            $error("report_begin: expected %0d, got %0d", want.start_ofs, got.start_ofs);
            mismatches++;
        end
        if (got.stop_ofs !== want.stop_ofs) begin
            $error("report_stop: expected %0d, got %0d", want.stop_ofs, got.stop_ofs);
            mismatches++;
        end
    endfunction
endclass

module tb_csi_window_report_parser_unit;

    localparam int RANDOM_BYTES   = 950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_reply_byte   = '0;
    logic       i_first_byte   = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_report_found;
    logic [9:0] o_row_count;
    logic [9:0] o_column_count;
    logic [6:0] o_report_begin;
    logic [7:0] o_report_stop;

    report_scoreboard sb = new();

    int unsigned bytes_sent     = 0;
    logic        no_gaps        = 1'b0;
    logic        pressure_req   = 1'b0;
    logic        pressure_taken = 1'b0;
    int unsigned hold_left      = 0;

    csi_window_report_parser_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_reply_byte   (i_reply_byte),
        .i_first_byte   (i_first_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_report_found (o_report_found),
        .o_row_count    (o_row_count),
        .o_column_count (o_column_count),
        .o_report_begin (o_report_begin),
        .o_report_stop  (o_report_stop)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off, quiet during the no-gap stretch
    always @(posedge i_clk) begin
        if (pressure_req && !pressure_taken) begin
            pressure_taken <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            i_stall        <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (no_gaps) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 30);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_report_found, o_row_count, o_column_count,
                              o_report_begin, o_report_stop});
        end
    end

    // watchdog: ends the run when no beat moves on either side for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // offer one byte, with random gaps ahead of it, and wait for the beat
    task automatic send_byte(input logic [7:0] ch, input logic first_flag);
        while (!no_gaps && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_reply_byte <= ch;
        i_first_byte <= first_flag;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(ch, first_flag);
        bytes_sent++;
    endtask

    // one reply: first-byte flag on its opening byte, rarely a stray one inside
    task automatic send_reply(input t_byte_q q, input bit stray_firsts);
        for (int k = 0; k < q.size(); k++) begin
            send_byte(q[k], (k == 0) || (stray_firsts && $urandom_range(199) == 0));
        end
    endtask

    function automatic void add_text(ref t_byte_q q, input string s);
        for (int k = 0; k < s.len(); k++) begin
            q.push_back(s[k]);
        end
    endfunction

    function automatic void add_digits(ref t_byte_q q, input int unsigned count);
        for (int k = 0; k < count; k++) begin
            q.push_back(cwrp_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    // rows or columns field: mostly in range, with empty, zero and oversize cases
    function automatic void add_size_field(ref t_byte_q q);
        int unsigned pick;
        int unsigned zeros;
        pick  = $urandom_range(99);
        zeros = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
        for (int k = 0; k < zeros; k++) begin
            q.push_back(cwrp_pkg::CH_ZERO);
        end
        if (pick < 55) begin
            add_text(q, $sformatf("%0d", $urandom_range(1, 999)));
        end else if (pick < 68) begin
            add_text(q, $sformatf("%0d", $urandom_range(1, 9)));
        end else if (pick < 74) begin
            add_text(q, $sformatf("%0d", ($urandom_range(1) == 0) ? 1 : 999));
        end else if (pick < 79) begin
            // empty field
        end else if (pick < 84) begin
            add_text(q, "0");
        end else if (pick < 93) begin
            add_text(q, $sformatf("%0d", $urandom_range(1000, 99999)));
        end else begin
            add_digits(q, $urandom_range(4, 12));
        end
    endfunction

    // well-formed report with random content
    function automatic void add_report(ref t_byte_q q);
        q.push_back(cwrp_pkg::CH_CSI);
        add_digits(q, $urandom_range(0, 4));
        q.push_back(cwrp_pkg::CH_SEMI);
        add_digits(q, $urandom_range(0, 4));
        q.push_back(cwrp_pkg::CH_SEMI);
        add_size_field(q);
        q.push_back(cwrp_pkg::CH_SEMI);
        add_size_field(q);
        q.push_back(cwrp_pkg::CH_SPACE);
        q.push_back(cwrp_pkg::CH_R);
    endfunction

    // report with one byte replaced, dropped or an extra separator slipped in
    function automatic void add_broken_report(ref t_byte_q q);
        t_byte_q     part;
        int unsigned at;
        add_report(part);
        at = $urandom_range(1, part.size() - 1);
        case ($urandom_range(2))
            0: part[at] = 8'($urandom_range(255));
            1: part.delete(at);
            default: part.insert(at, ($urandom_range(1) == 0) ? cwrp_pkg::CH_SEMI
                                                               : cwrp_pkg::CH_SPACE);
        endcase
        foreach (part[k]) q.push_back(part[k]);
    endfunction

    // raw bytes, partly drawn from the report syntax
    function automatic void add_noise(ref t_byte_q q, input int unsigned count);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(5))
                0: q.push_back(cwrp_pkg::CH_SEMI);
                1: q.push_back(cwrp_pkg::CH_SPACE);
                2: q.push_back(cwrp_pkg::CH_R);
                default: q.push_back(8'($urandom_range(255)));
            endcase
        end
    endfunction

    // stimulus
    initial begin : stimulus
        t_byte_q     q;
        int unsigned leftover;
        int unsigned stop_at;
        bit          pressure_done;
        pressure_done = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest report, then largest sizes and a second report in the same reply
        q = {};
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;1;1 r");
        send_reply(q, 1'b0);
        q = {};
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, "0123;4567;089;999 r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;999;56 r");
        send_reply(q, 1'b0);

        // saturated rows, empty columns, early space, extra separator, bad final byte
        q = {};
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;1000;5 r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;5; r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, "; ;");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;1;1; r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;2;3 x r");
        send_reply(q, 1'b0);

        // a CSI restarts a half-done report; zero sizes are refused
        q = {};
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;5");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;2;3 r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;0;0 r");
        send_reply(q, 1'b0);

        // a new reply cuts a report off halfway
        q = {};
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;4");
        send_reply(q, 1'b0);
        q = {};
        add_text(q, ";4 r");
        send_reply(q, 1'b0);

        // report ending on the last buffer byte, then bytes past the end
        q = {};
        for (int k = 0; k < 120; k++) begin
            q.push_back((k % 2 == 0) ? 8'h00 : 8'hFF);
        end
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;9;9 r");
        q.push_back(cwrp_pkg::CH_CSI);
        add_text(q, ";;1;1 r");
        send_reply(q, 1'b0);

        // random replies
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if (!pressure_done && bytes_sent >= stop_at - RANDOM_BYTES * 2 / 3) begin
                pressure_done = 1'b1;
                no_gaps      <= 1'b1;
                pressure_req <= 1'b1;
            end else if (no_gaps && bytes_sent >= stop_at - RANDOM_BYTES / 3) begin
                no_gaps <= 1'b0;
            end
            q = {};
            if ($urandom_range(99) < 60) begin
                add_noise(q, $urandom_range(0, 2));
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(9))
                    0, 1:    add_broken_report(q);
                    2:       add_noise(q, $urandom_range(1, 8));
                    default: add_report(q);
                endcase
            end
            // now and then a reply that runs past the buffer
            if ($urandom_range(19) == 0) begin
                add_noise(q, 110);
                add_report(q);
                add_report(q);
            end
            send_reply(q, 1'b1);
        end
        i_valid <= 1'b0;

        // drain the result side
        while (sb.owed_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        leftover = sb.owed_reports.size();
        if (leftover != 0) begin
            $error("%0d results never arrived", leftover);
        end
        $display("covered %0d bytes: %0d reports found, %0d result beats checked,",
                 bytes_sent, sb.reports, sb.checked);
        $display("%0d bytes past the buffer end, one long result-side hold-off",
                 sb.dropped_bytes);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/cwrp_pkg.sv
sv/csi_window_report_parser_unit.sv
verif/tb_csi_window_report_parser_unit.sv
